@@ sv/rqt_pkg.sv @@
// ----------------------------------------------------------------------------
// rqt_pkg
// Shared types and constants of the read quality trimmer.
// ----------------------------------------------------------------------------
package rqt_pkg;

  localparam int unsigned QC_W        = 7;
  localparam int unsigned PHRED_W     = 7;
  localparam int unsigned CFG_PHRED_W = 7;
  localparam int unsigned CFG_LEN_W   = 13;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned CFG_IDX_W   = 2;

  // largest phred a 7-bit character can carry
  localparam int unsigned PHRED_MAX = 94;

  localparam logic [QC_W-1:0] PHRED_OFFSET = 7'd33;

  localparam logic [CFG_PHRED_W-1:0] MIN_PHRED_RST      = 7'd20;
  localparam logic [CFG_PHRED_W-1:0] MIN_MEAN_PHRED_RST = 7'd20;
  localparam logic [CFG_LEN_W-1:0]   MIN_REGION_LEN_RST = 13'd15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_PHRED      = 2'd0,
    CFG_MIN_MEAN_PHRED = 2'd1,
    CFG_MIN_REGION_LEN = 2'd2
  } cfg_reg_e;

endpackage

@@ sv/rqt_score.sv @@
// ----------------------------------------------------------------------------
// rqt_score
// Running score of one read: start search, clamped running sum, best end.
// ----------------------------------------------------------------------------
module rqt_score import rqt_pkg::*; #(
  parameter int unsigned MAX_READ_LENGTH = 4096,
  localparam int unsigned CNT_W = $clog2(MAX_READ_LENGTH + 1),
  localparam int unsigned POS_W = $clog2(MAX_READ_LENGTH),
  localparam int unsigned SUM_W = $clog2(PHRED_MAX * MAX_READ_LENGTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   take_i,
  input  logic [PHRED_W-1:0]     phred_i,
  input  logic                   last_i,
  input  logic [CFG_PHRED_W-1:0] min_phred_i,
  output logic                   found_o,
  output logic [POS_W-1:0]       left_o,
  output logic [POS_W-1:0]       right_o,
  output logic [SUM_W-1:0]       at_best_o
);

  logic             searching_q, searching_d;
  logic [CNT_W-1:0] char_idx_q, char_idx_d;
  logic [POS_W-1:0] left_q, left_d;
  logic [POS_W-1:0] right_q, right_d;
  logic [SUM_W-1:0] run_q, run_d;
  logic [SUM_W-1:0] best_q, best_d;
  logic [SUM_W-1:0] total_q, total_d;
  logic [SUM_W-1:0] at_best_q, at_best_d;

  logic             active;
  logic [POS_W-1:0] pos;
  logic [SUM_W-1:0] phred_x;
  logic [SUM_W-1:0] minp_x;
  logic [SUM_W-1:0] sum;

  assign active  = (char_idx_q != CNT_W'(MAX_READ_LENGTH));
  assign pos     = char_idx_q[POS_W-1:0];
  assign phred_x = SUM_W'(phred_i);
  assign minp_x  = SUM_W'(min_phred_i);
  assign sum     = run_q + phred_x;

  always_comb begin
    searching_d = searching_q;
    char_idx_d  = char_idx_q;
    left_d      = left_q;
    right_d     = right_q;
    run_d       = run_q;
    best_d      = best_q;
    total_d     = total_q;
    at_best_d   = at_best_q;
    if (active) begin
      if (searching_q) begin
        if (phred_i >= min_phred_i) begin
          searching_d = 1'b0;
          left_d      = pos;
          right_d     = pos;
          run_d       = phred_x - minp_x;
          best_d      = phred_x - minp_x;
          total_d     = phred_x;
          at_best_d   = phred_x;
        end
      end else begin
        total_d = total_q + phred_x;
        run_d   = (sum < minp_x) ? '0 : sum - minp_x;
        if (run_d >= best_q) begin
          best_d    = run_d;
          right_d   = pos;
          at_best_d = total_d;
        end
      end
      char_idx_d = char_idx_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      searching_q <= 1'b1;
      char_idx_q  <= '0;
      left_q      <= '0;
      right_q     <= '0;
      run_q       <= '0;
      best_q      <= '0;
      total_q     <= '0;
      at_best_q   <= '0;
    end else if (take_i) begin
      if (last_i) begin
        searching_q <= 1'b1;
        char_idx_q  <= '0;
        left_q      <= '0;
        right_q     <= '0;
        run_q       <= '0;
        best_q      <= '0;
        total_q     <= '0;
        at_best_q   <= '0;
      end else begin
        searching_q <= searching_d;
        char_idx_q  <= char_idx_d;
        left_q      <= left_d;
        right_q     <= right_d;
        run_q       <= run_d;
        best_q      <= best_d;
        total_q     <= total_d;
        at_best_q   <= at_best_d;
      end
    end
  end

  // state of the read after this item, for the verdict
  assign found_o   = !searching_d;
  assign left_o    = left_d;
  assign right_o   = right_d;
  assign at_best_o = at_best_d;

endmodule

@@ sv/read_quality_trimmer_top.sv @@
// ----------------------------------------------------------------------------
// read_quality_trimmer_top
// Running-score quality trimming of one read, one quality character per item.
//
// Takes one quality character (phred + 33) per cycle while the input is not
// held, and gives one verdict per read, after the character marked last:
// rejected, or the 1-based first and last kept positions. Throughput is one
// character per clock unless a stalled verdict holds the input. A verdict
// passes the input register, where the score is updated, and the end-of-read
// snapshot, from which the verdict (length, one multiply and the two
// compares) is registered. A stalled verdict holds the next last character
// in the input register until the output frees up. Characters beyond
// MAX_READ_LENGTH are not scored. The user must write configuration registers
// only while no read is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module read_quality_trimmer_top import rqt_pkg::*; #(
  parameter int unsigned MAX_READ_LENGTH = 4096
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                      cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]                     cfg_data_i,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic [QC_W-1:0]                           quality_char_i,
  input  logic                                      last_char_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic                                      rejected_o,
  output logic [$clog2(MAX_READ_LENGTH + 1)-1:0]    region_start_o,
  output logic [$clog2(MAX_READ_LENGTH + 1)-1:0]    region_stop_o
);

  localparam int unsigned CNT_W   = $clog2(MAX_READ_LENGTH + 1);
  localparam int unsigned POS_W   = $clog2(MAX_READ_LENGTH);
  localparam int unsigned SUM_W   = $clog2(PHRED_MAX * MAX_READ_LENGTH + 1);
  localparam int unsigned MUL_W   = CFG_PHRED_W + CNT_W;
  localparam int unsigned CMP_W   = (MUL_W > SUM_W) ? MUL_W : SUM_W;
  localparam int unsigned LCMP_W  = (CNT_W > CFG_LEN_W) ? CNT_W : CFG_LEN_W;

  // configuration
  logic [CFG_PHRED_W-1:0] min_phred_q;
  logic [CFG_PHRED_W-1:0] min_mean_q;
  logic [CFG_LEN_W-1:0]   min_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_phred_q <= MIN_PHRED_RST;
      min_mean_q  <= MIN_MEAN_PHRED_RST;
      min_len_q   <= MIN_REGION_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_MIN_PHRED:      min_phred_q <= cfg_data_i[CFG_PHRED_W-1:0];
        CFG_MIN_MEAN_PHRED: min_mean_q  <= cfg_data_i[CFG_PHRED_W-1:0];
        CFG_MIN_REGION_LEN: min_len_q   <= cfg_data_i[CFG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake and stage control
  logic s0_valid_q;
  logic s0_last_q;
  logic [QC_W-1:0] s0_qc_q;
  logic s0_take;
  logic fin_valid_q;
  logic fin_ready;
  logic out_free;
  logic out_valid_q;

  assign out_free   = !out_valid_q || out_ready_i;
  assign fin_ready  = !fin_valid_q || out_free;
  assign s0_take    = s0_valid_q && (!s0_last_q || fin_ready);
  assign in_ready_o = !s0_valid_q || s0_take;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s0_qc_q   <= quality_char_i;
      s0_last_q <= last_char_i;
    end
  end

  // score update
  logic [PHRED_W-1:0] phred;
  logic               sc_found;
  logic [POS_W-1:0]   sc_left;
  logic [POS_W-1:0]   sc_right;
  logic [SUM_W-1:0]   sc_at_best;

  assign phred = (s0_qc_q >= PHRED_OFFSET) ? PHRED_W'(s0_qc_q - PHRED_OFFSET) : '0;

  rqt_score #(
    .MAX_READ_LENGTH(MAX_READ_LENGTH)
  ) u_score (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (s0_take),
    .phred_i     (phred),
    .last_i      (s0_last_q),
    .min_phred_i (min_phred_q),
    .found_o     (sc_found),
    .left_o      (sc_left),
    .right_o     (sc_right),
    .at_best_o   (sc_at_best)
  );

  // end-of-read snapshot
  logic             fin_found_q;
  logic [POS_W-1:0] fin_left_q;
  logic [POS_W-1:0] fin_right_q;
  logic [SUM_W-1:0] fin_total_q;
  logic             fin_load;

  assign fin_load = s0_take && s0_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (fin_load) begin
      fin_valid_q <= 1'b1;
    end else if (out_free) begin
      fin_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      fin_found_q <= sc_found;
      fin_left_q  <= sc_left;
      fin_right_q <= sc_right;
      fin_total_q <= sc_at_best;
    end
  end

  // verdict
  logic [CNT_W-1:0] len;
  logic [MUL_W-1:0] mean_need;
  logic             len_ok;
  logic             mean_ok;
  logic             keep;
  logic             rejected_q;
  logic [CNT_W-1:0] start_q;
  logic [CNT_W-1:0] stop_q;

  assign len       = CNT_W'(fin_right_q) - CNT_W'(fin_left_q) + CNT_W'(1);
  assign mean_need = MUL_W'(min_mean_q) * MUL_W'(len);
  assign len_ok    = LCMP_W'(len) >= LCMP_W'(min_len_q);
  assign mean_ok   = CMP_W'(fin_total_q) >= CMP_W'(mean_need);
  assign keep      = fin_found_q && len_ok && mean_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fin_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && fin_valid_q) begin
      rejected_q <= !keep;
      start_q    <= keep ? CNT_W'(fin_left_q) + CNT_W'(1) : '0;
      stop_q     <= keep ? CNT_W'(fin_right_q) + CNT_W'(1) : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign rejected_o     = rejected_q;
  assign region_start_o = start_q;
  assign region_stop_o  = stop_q;

endmodule

@@ sv/rqt_checker.sv @@
// ----------------------------------------------------------------------------
// rqt_checker
// Port-level checks of the read quality trimmer, bound to the top level.
// ----------------------------------------------------------------------------
module rqt_checker import rqt_pkg::*; #(
  parameter int unsigned MAX_READ_LENGTH = 4096
) (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   cfg_we_i,
  input logic                                   in_valid_i,
  input logic                                   in_ready_o,
  input logic [QC_W-1:0]                        quality_char_i,
  input logic                                   last_char_i,
  input logic                                   out_valid_o,
  input logic                                   out_ready_i,
  input logic                                   rejected_o,
  input logic [$clog2(MAX_READ_LENGTH + 1)-1:0] region_start_o,
  input logic [$clog2(MAX_READ_LENGTH + 1)-1:0] region_stop_o
);

  // stalled verdict holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rejected_o) &&
      $stable(region_start_o) && $stable(region_stop_o))
    else $error("verdict changed while stalled");

  // rejected reads carry no region
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> region_start_o == '0 && region_stop_o == '0)
    else $error("rejected read with non-zero region");

  // kept region is ordered and 1-based
  a_keep_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !rejected_o |-> region_start_o != '0 &&
      region_start_o <= region_stop_o)
    else $error("kept region out of order");

  // offered item waits unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(quality_char_i) &&
      $stable(last_char_i))
    else $error("input item changed while waiting");

  // settings change only while idle
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !out_valid_o && in_ready_o)
    else $error("configuration written while busy");

endmodule

bind read_quality_trimmer_top rqt_checker #(
  .MAX_READ_LENGTH(MAX_READ_LENGTH)
) u_rqt_checker (.*);

@@ dv/read_quality_trimmer_checker.sv @@
// ----------------------------------------------------------------------------
// read_quality_trimmer_checker
// Watches the configuration port and both channels of the read quality
// trimmer, works out the verdict of every read from the accepted quality
// characters and compares it field by field with the verdict the block gives.
// ----------------------------------------------------------------------------
module read_quality_trimmer_checker import rqt_pkg::*; #(
  parameter int unsigned MAX_READ_LENGTH = 4096,
  parameter int unsigned POS_W           = $clog2(MAX_READ_LENGTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [QC_W-1:0]       quality_char_i,
  input  logic                  last_char_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic                  rejected_i,
  input  logic [POS_W-1:0]      region_start_i,
  input  logic [POS_W-1:0]      region_stop_i,
  output int unsigned           pending_o,
  output int unsigned           errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             rejected;
    logic [POS_W-1:0] first_pos;
    logic [POS_W-1:0] last_pos;
  } verdict_t;

  verdict_t verdict_q[$];

  int unsigned thr      = MIN_PHRED_RST;
  int unsigned min_mean = MIN_MEAN_PHRED_RST;
  int unsigned min_len  = MIN_REGION_LEN_RST;

  bit          hunting = 1'b1;
  int unsigned char_cnt, left_pos, right_pos;
  int unsigned run_score, best_score, total, total_at_best;
  int unsigned errors;

  function automatic void clear_read();
    hunting       = 1'b1;
    char_cnt      = 0;
    left_pos      = 0;
    right_pos     = 0;
    run_score     = 0;
    best_score    = 0;
    total         = 0;
    total_at_best = 0;
  endfunction

  function automatic void score_char(input logic [QC_W-1:0] qc, input logic last_c);
    int unsigned phred;
    int unsigned sum;
    int unsigned span;
    verdict_t    v;
    phred = (qc >= PHRED_OFFSET) ? int'(qc - PHRED_OFFSET) : 0;
    if (char_cnt < MAX_READ_LENGTH) begin
      if (hunting) begin
        if (phred >= thr) begin
          hunting       = 1'b0;
          left_pos      = char_cnt;
          right_pos     = char_cnt;
          run_score     = phred - thr;
          best_score    = run_score;
          total         = phred;
          total_at_best = phred;
        end
      end else begin
        sum       = run_score + phred;
        total    += phred;
        run_score = (sum < thr) ? 0 : sum - thr;
        if (run_score >= best_score) begin
          best_score    = run_score;
          right_pos     = char_cnt;
          total_at_best = total;
        end
      end
      char_cnt++;
    end
    if (last_c) begin
      v = '{rejected: 1'b1, first_pos: '0, last_pos: '0};
      if (!hunting) begin
        span = right_pos - left_pos + 1;
        if (span >= min_len && total_at_best >= min_mean * span) begin
          v.rejected  = 1'b0;
          v.first_pos = POS_W'(left_pos + 1);
          v.last_pos  = POS_W'(right_pos + 1);
        end
      end
      verdict_q = {verdict_q, v};
      clear_read();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      verdict_q.delete();
      thr      = MIN_PHRED_RST;
      min_mean = MIN_MEAN_PHRED_RST;
      min_len  = MIN_REGION_LEN_RST;
      clear_read();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_PHRED:      thr      = cfg_data_i[CFG_PHRED_W-1:0];
          CFG_MIN_MEAN_PHRED: min_mean = cfg_data_i[CFG_PHRED_W-1:0];
          CFG_MIN_REGION_LEN: min_len  = cfg_data_i[CFG_LEN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          if (errors < 10)
            $display("%t: verdict with none outstanding: rejected %0b start %0d stop %0d",
                     $time, rejected_i, region_start_i, region_stop_i);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          if (rejected_i !== want.rejected || region_start_i !== want.first_pos ||
              region_stop_i !== want.last_pos) begin
            if (errors < 10)
              $display("%t: verdict mismatch: expected %0b %0d %0d, got %0b %0d %0d",
                       $time, want.rejected, want.first_pos, want.last_pos,
                       rejected_i, region_start_i, region_stop_i);
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        score_char(quality_char_i, last_char_i);
      pending_o <= verdict_q.size();
      errors_o  <= errors;
    end
  end

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench of the read quality trimmer.
//
// Streams reads of quality characters into the block: a few hand-made reads
// at the reset settings, then random reads under several threshold settings,
// extremes among them. Both channels idle in short random bursts, and once
// the output holds off for a long stretch so that the block backs up. The
// checker beside the block predicts every verdict and counts the mismatches.
// ----------------------------------------------------------------------------
module tb import rqt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_LEN      = 4096;
  localparam int unsigned POS_W        = $clog2(MAX_LEN + 1);
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i      = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic [QC_W-1:0]       quality_char_i = '0;
  logic                  last_char_i    = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic                  rejected_o;
  logic [POS_W-1:0]      region_start_o;
  logic [POS_W-1:0]      region_stop_o;

  int unsigned pending;
  int unsigned errors;

  bit calm     = 1'b0;
  bit hold_req = 1'b0;
  int thr      = MIN_PHRED_RST;
  int phase_chars;

  always #5 clk_i = ~clk_i;

  read_quality_trimmer_top #(.MAX_READ_LENGTH(MAX_LEN)) u_dut (.*);

  read_quality_trimmer_checker #(.MAX_READ_LENGTH(MAX_LEN)) u_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_i     (in_ready_o),
    .quality_char_i,
    .last_char_i,
    .out_valid_i    (out_valid_o),
    .out_ready_i,
    .rejected_i     (rejected_o),
    .region_start_i (region_start_o),
    .region_stop_i  (region_stop_o),
    .pending_o      (pending),
    .errors_o       (errors)
  );

  task automatic send_char(input logic [QC_W-1:0] qc, input logic last_c);
    in_valid_i     <= 1'b1;
    quality_char_i <= qc;
    last_char_i    <= last_c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    phase_chars++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic send_read();
    int len;
    int kind;
    int base;
    int p;
    int r;
    logic [QC_W-1:0] qc;
    r    = $urandom_range(0, 19);
    len  = (r == 0) ? $urandom_range(41, 200) : (r < 3) ? $urandom_range(1, 3) :
           $urandom_range(4, 40);
    kind = $urandom_range(0, 9);
    base = thr + $urandom_range(0, 20) - 6;
    for (int i = 0; i < len; i++) begin
      p = base + $urandom_range(0, 24) - 12;
      // falling quality towards the end of the read
      if (kind < 3) p = p + 10 - (i * 24) / len;
      if (p < 0) p = 0;
      if (p > PHRED_MAX) p = PHRED_MAX;
      if (kind == 9 || $urandom_range(0, 31) == 0) qc = QC_W'($urandom_range(0, 127));
      else qc = QC_W'(p + PHRED_OFFSET);
      send_char(qc, i == len - 1);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input int p, input int m, input int l);
    write_reg(CFG_MIN_PHRED, CFG_DATA_W'(p));
    write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom_range(0, 8191)));
    write_reg(CFG_MIN_MEAN_PHRED, CFG_DATA_W'(m));
    write_reg(CFG_MIN_REGION_LEN, CFG_DATA_W'(l));
    cfg_we_i <= 1'b0;
    thr = p & 'h7F;
  endtask

  task automatic drain();
    int n;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    n = 0;
    while (pending != 0 && n < 5000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // output side
  initial begin
    int n;
    bit held;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        n = calm ? 1 : $urandom_range(1, 8);
        repeat (n) @(posedge clk_i);
      end
    end
  end

  initial begin
    int quota;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: empty of good characters, low and high codes, short region
    send_char(7'd0, 1'b1);
    send_char(7'd32, 1'b0);
    for (int i = 0; i < 14; i++) send_char(7'd127, 1'b0);
    send_char(7'd127, 1'b1);
    send_char(PHRED_OFFSET, 1'b0);
    send_char(7'd53, 1'b1);
    send_char(7'd126, 1'b1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          apply_settings(MIN_PHRED_RST, MIN_MEAN_PHRED_RST, MIN_REGION_LEN_RST);
          quota = 280;
          hold_req <= 1'b1;
        end
        1: begin
          apply_settings(0, 0, 0);
          quota = 220;
        end
        2: begin
          apply_settings(93, 93, 1);
          quota = 100;
        end
        3: begin
          apply_settings(8191, 8191, 8191);
          quota = 80;
        end
        7: begin
          apply_settings($urandom_range(10, 30), $urandom_range(10, 30),
                         $urandom_range(0, 20));
          quota = 180;
          calm <= 1'b1;
        end
        default: begin
          apply_settings($urandom_range(0, 40), $urandom_range(0, 45),
                         $urandom_range(0, 40));
          quota = 200;
        end
      endcase
      phase_chars = 0;
      while (phase_chars < quota) send_read();
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
